// ===== hdl/assert_macros.svh =====
// Concurrent check helpers; clk and rst are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every clock edge out of reset.
`define SMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define SMS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sms_pkg;

  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int ROW_W     = 5;
  localparam int COL_W     = 5;
  localparam int VAL_W     = 32;
  // Flat position width: covers 63 * 63 elements.
  localparam int POS_W     = 12;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_PROBE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic write_word;
    logic start;
    logic advance;
    logic issue;
    logic mark_hit;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/sms_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sms_in_if import sms_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [ROW_W-1:0]        row;
  logic [COL_W-1:0]        col;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, action, row, col, value, input ready);
  modport sink (input valid, action, row, col, value, output ready);
endinterface

interface sms_out_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, found, input ready);
  modport sink (input valid, found, output ready);
endinterface

`default_nettype wire

// ===== hdl/sms_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sms_controller import sms_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_action,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output dp_cmd_t         cmd,
  input  wire dp_status_t status
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;
  logic   in_take;

  assign out_free = !out_valid || out_ready;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_take) begin
          if (in_action == ACT_QUERY) begin
            cmd.start  = 1'b1;
            state_next = S_SETUP;
          end else begin
            cmd.write_word = 1'b1;
          end
        end
      end
      S_SETUP: begin
        // empty matrix: skip straight to the not-found answer
        if (status.empty) begin
          state_next = S_DONE;
        end else begin
          cmd.issue  = 1'b1;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.advance = 1'b1;
        if (status.hit) begin
          cmd.mark_hit = 1'b1;
          state_next   = S_DONE;
        end else if (status.empty) begin
          state_next = S_DONE;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      S_DONE: begin
        // hold the answer until the output register is free
        if (out_free) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `SMS_ASSERT_IMP(a_emit_into_free, cmd.emit, out_free, "result emitted over a pending word")
  `SMS_ASSERT_IMP(a_issue_nonempty, cmd.issue, !status.empty, "probe issued on an empty range")
  `SMS_ASSERT_NEXT(a_query_setup, in_take && (in_action == ACT_QUERY), state == S_SETUP,
                   "query accepted without entering setup")

endmodule

`default_nettype wire

// ===== hdl/sms_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sms_datapath import sms_pkg::*; #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data,
  input  wire logic [ROW_W-1:0]        row,
  input  wire logic [COL_W-1:0]        col,
  input  wire logic signed [VAL_W-1:0] value,
  input  wire dp_cmd_t                 cmd,
  output dp_status_t                   status,
  output logic                         found
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CFG_W-1:0]        rows_in_use;
  logic [CFG_W-1:0]        cols_in_use;
  logic [CFG_W-1:0]        rows_eff;
  logic [CFG_W-1:0]        cols_eff;
  logic [POS_W-1:0]        wpos;
  logic [POS_W-1:0]        n_total;
  logic                    write_ok;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd_data;
  logic signed [VAL_W-1:0] key;
  logic [POS_W-1:0]        lo;
  logic [POS_W-1:0]        hi;
  logic [POS_W-1:0]        mid;
  logic [POS_W-1:0]        cand_lo;
  logic [POS_W-1:0]        cand_hi;
  logic [POS_W-1:0]        cand_mid;
  logic                    go_up;
  logic                    hit_seen;

  // clamp the configured size to the store's shape
  assign rows_eff = (int'(rows_in_use) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : rows_in_use;
  assign cols_eff = (int'(cols_in_use) > MAX_COLS) ? CFG_W'(MAX_COLS) : cols_in_use;

  assign write_ok = cmd.write_word && (CFG_W'(row) < rows_eff) && (CFG_W'(col) < cols_eff);
  assign wpos     = POS_W'(row) * POS_W'(cols_eff) + POS_W'(col);
  assign n_total  = POS_W'(rows_eff) * POS_W'(cols_eff);

  // narrow the range around the last probe, or keep it on the first probe
  assign go_up = key > rd_data;
  always_comb begin
    if (cmd.advance) begin
      cand_lo = go_up ? mid + POS_W'(1) : lo;
      cand_hi = go_up ? hi : mid;
    end else begin
      cand_lo = lo;
      cand_hi = hi;
    end
  end
  assign cand_mid = cand_lo + ((cand_hi - cand_lo - POS_W'(1)) >> 1);

  assign status.empty = cand_lo >= cand_hi;
  assign status.hit   = rd_data == key;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= '0;
      cols_in_use <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS: rows_in_use <= cfg_data;
        REG_COLS: cols_in_use <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (write_ok) begin
      mem[AW'(wpos)] <= value;
    end
    if (cmd.issue) begin
      rd_data <= mem[AW'(cand_mid)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo  <= '0;
      hi  <= '0;
      mid <= '0;
    end else if (cmd.start) begin
      lo <= '0;
      hi <= n_total;
    end else if (cmd.issue) begin
      lo  <= cand_lo;
      hi  <= cand_hi;
      mid <= cand_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_seen <= 1'b0;
      found    <= 1'b0;
    end else begin
      if (cmd.start) begin
        key <= value;
      end
      if (cmd.start) begin
        hit_seen <= 1'b0;
      end else if (cmd.mark_hit) begin
        hit_seen <= 1'b1;
      end
      if (cmd.emit) begin
        found <= hit_seen;
      end
    end
  end

  `SMS_ASSERT(a_bounds_order, lo <= hi, "search bounds crossed")
  `SMS_ASSERT_NEXT(a_probe_inside, cmd.issue, (mid >= lo) && (mid < hi),
                   "probe position outside the live range")
  `SMS_ASSERT_NEXT(a_found_held, !cmd.emit && !rst, $stable(found),
                   "result word changed without an emit")

endmodule

`default_nettype wire

// ===== hdl/sorted_matrix_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Search for a value in a row-major sorted matrix of signed 32-bit words.
// Input channel carries words with action, row, col and value. A load word
// writes value at row * cols_in_use + col and gives no result; a load outside
// the configured size is dropped. A query word runs a binary search over
// flat positions 0 .. rows*cols-1 and gives one output word with found.
// Configuration: cfg_we with cfg_index 0 (rows_in_use) or 1 (cols_in_use).
// The user must write it only while the block is idle; the block itself does
// not enforce this. Sizes above MAX_ROWS / MAX_COLS clamp. Loads are taken
// back to back while idle. A query makes P probes, P being at most
// ceil(log2(rows*cols + 1)), and no new word is taken until its result has
// gone into the output register. Each probe is one read of the element
// memory and one compare; the next probe address is formed in the same cycle.
// The query steps through setup, probe and done states; done registers found.
// Reset clears the sizes to zero and all handshake state; element contents
// are undefined until loaded. A stalled receiver holds the output word, and
// loads are still taken; a finished query waits until the output is free.
module sorted_matrix_search import sms_pkg::*; #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  sms_in_if.sink                    in,
  sms_out_if.source                 out,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;
  logic       found;

  assign in.ready  = in_ready;
  assign out.valid = out_valid;
  assign out.found = found;

  sms_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in.valid),
    .in_action (in.action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out.ready),
    .cmd       (cmd),
    .status    (status)
  );

  sms_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .row       (in.row),
    .col       (in.col),
    .value     (in.value),
    .cmd       (cmd),
    .status    (status),
    .found     (found)
  );

endmodule

`default_nettype wire
